/* rtl/fsfl_pkg.sv */
`timescale 1ns / 1ps

package fsfl_pkg;

    // pool geometry
    localparam int SLOTS  = 1024;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LINK_W = SLOT_W + 1;
    localparam int CNT_W  = LINK_W;

    // null link marks the end of the free list
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RANGE     = 2'd2,
        ST_DOUBLE    = 2'd3
    } t_status;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;  // latch request and start the memory reads
        logic commit;  // apply the update and load the result register
    } t_cmd;

endpackage

/* rtl/fsfl_ctrl.sv */
`timescale 1ns / 1ps

module fsfl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output fsfl_pkg::t_cmd    o_cmd
);
    import fsfl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept, w_commit, w_taken;

    // handshake decode
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_taken  = r_out_valid && !i_stall;
    assign w_commit = (r_state == S_EXEC) && (!r_out_valid || !i_stall);

    assign o_cmd.accept = w_accept;
    assign o_cmd.commit = w_commit;
    assign o_valid      = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        priority if (w_commit) n_out_valid = 1'b1;
        else if (w_taken)      n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/fsfl_dp.sv */
`timescale 1ns / 1ps

module fsfl_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fsfl_pkg::t_cmd                i_cmd,
    input  logic                          i_req_type,
    input  logic [fsfl_pkg::SLOT_W-1:0]   i_slot_index,
    output logic [fsfl_pkg::SLOT_W-1:0]   o_slot,
    output logic [1:0]                    o_status,
    output logic [fsfl_pkg::CNT_W-1:0]    o_live_count
);
    import fsfl_pkg::*;

    // link and free-mark stores; entries at or above the fill point are untouched
    logic [LINK_W-1:0] mem_link [SLOTS];
    logic              mem_mark [SLOTS];

    logic [LINK_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [LINK_W-1:0] r_fill, n_fill;

    logic              r_req_type;
    logic [SLOT_W-1:0] r_idx;
    logic [LINK_W-1:0] r_link_q;
    logic              r_mark_q;
    logic              r_head_new;
    logic              r_idx_new;

    logic [SLOT_W-1:0] r_slot;
    t_status           r_status;
    logic [CNT_W-1:0]  r_live;

    logic [SLOT_W-1:0] w_head_slot;
    logic [LINK_W-1:0] w_next;
    logic              w_is_free;
    logic              w_link_we;
    logic              w_mark_we;
    logic [SLOT_W-1:0] w_mark_addr;
    logic              w_mark_val;
    logic [SLOT_W-1:0] n_slot;
    t_status           n_status;

    assign w_head_slot = r_head[SLOT_W-1:0];

    // untouched entries read as their reset values
    assign w_next    = r_head_new ? LINK_W'(r_head + 1'b1) : r_link_q;
    assign w_is_free = r_idx_new ? 1'b1 : r_mark_q;

    // request evaluation
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_fill      = r_fill;
        n_slot      = '0;
        n_status    = ST_OK;
        w_link_we   = 1'b0;
        w_mark_we   = 1'b0;
        w_mark_addr = r_idx;
        w_mark_val  = 1'b1;
        if (r_req_type == REQ_ALLOC) begin
            if (r_head >= NULL_LINK) begin
                n_status = ST_EXHAUSTED;
            end else begin
                n_slot      = w_head_slot;
                n_head      = w_next;
                n_count     = CNT_W'(r_count + 1'b1);
                w_mark_we   = 1'b1;
                w_mark_addr = w_head_slot;
                w_mark_val  = 1'b0;
                if (r_head_new) n_fill = LINK_W'(r_fill + 1'b1);
            end
        end else begin
            priority if ({1'b0, r_idx} >= NULL_LINK) begin
                n_status = ST_RANGE;
            end else if (w_is_free) begin
                n_status = ST_DOUBLE;
            end else begin
                w_link_we = 1'b1;
                w_mark_we = 1'b1;
                n_head    = {1'b0, r_idx};
                if (r_count != '0) n_count = CNT_W'(r_count - 1'b1);
            end
        end
    end

    // request capture and synchronous reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type <= i_req_type;
            r_idx      <= i_slot_index;
            r_link_q   <= mem_link[w_head_slot];
            r_mark_q   <= mem_mark[i_slot_index];
            r_head_new <= (r_head >= r_fill);
            r_idx_new  <= ({1'b0, i_slot_index} >= r_fill);
        end
    end

    // store writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_link_we) mem_link[r_idx] <= r_head;
        if (i_cmd.commit && w_mark_we) mem_mark[w_mark_addr] <= w_mark_val;
    end

    // list head, live count and fill point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_fill  <= '0;
        end else if (i_cmd.commit) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_fill  <= n_fill;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_slot   <= n_slot;
            r_status <= n_status;
            r_live   <= n_count;
        end
    end

    assign o_slot       = r_slot;
    assign o_status     = r_status;
    assign o_live_count = r_live;

endmodule

/* rtl/fixed_slot_free_list_allocator.sv */
`timescale 1ns / 1ps

// LIFO free-list allocator over a fixed pool of slots. Each request (allocate,
// or free of a given index) yields exactly one result with slot, status and the
// live count after the request. A request is handled as a read of the link and
// free-mark memories, whose read data is registered, then an update of the
// list that loads the result register; the next request can be taken in the
// cycle after the update, and none is taken while one is in flight. A result
// waiting to be taken stalls only the update of the following request. No
// clearing pass runs after reset: a fill point marks which slots have never
// been allocated, and those read back as their reset contents, so the block
// takes requests straight out of reset. Errors (pool exhausted, index out of
// range, double free) leave state as it is.

module fixed_slot_free_list_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic [fsfl_pkg::SLOT_W-1:0]   i_slot_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [fsfl_pkg::SLOT_W-1:0]   o_slot,
    output logic [1:0]                    o_status,
    output logic [fsfl_pkg::CNT_W-1:0]    o_live_count
);
    import fsfl_pkg::*;

    t_cmd w_cmd;

    // sequencing
    fsfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    // list state, memories and result register
    fsfl_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_req_type   (i_req_type),
        .i_slot_index (i_slot_index),
        .o_slot       (o_slot),
        .o_status     (o_status),
        .o_live_count (o_live_count)
    );

endmodule

/* dv/fsfl_pool_checker.sv */
`timescale 1ns / 1ps

module fsfl_pool_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic                          i_req_type,
    input  logic [fsfl_pkg::SLOT_W-1:0]   i_req_slot,
    input  logic                          i_grant_valid,
    input  logic                          i_grant_stall,
    input  logic [fsfl_pkg::SLOT_W-1:0]   i_grant_slot,
    input  logic [1:0]                    i_grant_status,
    input  logic [fsfl_pkg::CNT_W-1:0]    i_grant_live,
    output int                            o_fault_count,
    output int                            o_grants_due
);
    import fsfl_pkg::*;

    // one result of the allocator
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_status           status;
        logic [CNT_W-1:0]  live;
    } t_grant;

    // shadow copy of the pool
    logic [LINK_W-1:0] next_free [SLOTS];
    logic              is_free   [SLOTS];
    logic [LINK_W-1:0] head;
    logic [CNT_W-1:0]  live_total;

    t_grant grant_q [$];
    int     faults;

    // apply one request to the shadow pool and return the grant it yields
    function automatic t_grant serve_request(input logic kind,
                                             input logic [SLOT_W-1:0] idx);
        t_grant g;
        g.slot   = '0;
        g.status = ST_OK;
        if (kind == REQ_ALLOC) begin
            if (head >= LINK_W'(SLOTS)) begin
                g.status = ST_EXHAUSTED;
            end else begin
                g.slot = head[SLOT_W-1:0];
                is_free[head[SLOT_W-1:0]] = 1'b0;
                head = next_free[head[SLOT_W-1:0]];
                live_total = live_total + 1'b1;
            end
        end else if (int'(idx) >= SLOTS) begin
            g.status = ST_RANGE;
        end else if (is_free[idx]) begin
            g.status = ST_DOUBLE;
        end else begin
            // push the slot back onto the head of the list
            is_free[idx]   = 1'b1;
            next_free[idx] = head;
            head           = {1'b0, idx};
            if (live_total != '0)
                live_total = live_total - 1'b1;
        end
        g.live = live_total;
        return g;
    endfunction

    // watch both channels, compare grants in order
    always @(posedge i_clk) begin
        t_grant want;
        t_grant seen;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                next_free[i] = LINK_W'(i + 1);
                is_free[i]   = 1'b1;
            end
            next_free[SLOTS-1] = NULL_LINK;
            head       = '0;
            live_total = '0;
            grant_q.delete();
            faults = 0;
        end else begin
            if (i_grant_valid && !i_grant_stall) begin
                seen.slot   = i_grant_slot;
                seen.status = t_status'(i_grant_status);
                seen.live   = i_grant_live;
                if (grant_q.size() == 0) begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t: grant with no request waiting:", $time,
                                 " slot %0d status %0d live %0d",
                                 i_grant_slot, i_grant_status, i_grant_live);
                end else begin
                    want = grant_q.pop_front();
                    if (seen !== want) begin
                        faults++;
                        if (faults <= 10)
                            $display("%0t: grant mismatch:", $time,
                                     " expected slot %0d status %0d live %0d,",
                                     want.slot, want.status, want.live,
                                     " got slot %0d status %0d live %0d",
                                     i_grant_slot, i_grant_status, i_grant_live);
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                grant_q.push_back(serve_request(i_req_type, i_req_slot));
        end
        o_fault_count <= faults;
        o_grants_due  <= grant_q.size();
    end

endmodule

/* dv/tb_fixed_slot_free_list_allocator.sv */
`timescale 1ns / 1ps

module tb_fixed_slot_free_list_allocator;
    import fsfl_pkg::*;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_REQUESTS = 700;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_stall;
    logic              i_req_type   = REQ_ALLOC;
    logic [SLOT_W-1:0] i_slot_index = '0;
    logic              o_valid;
    logic              i_stall      = 1'b0;
    logic [SLOT_W-1:0] o_slot;
    logic [1:0]        o_status;
    logic [CNT_W-1:0]  o_live_count;

    int fault_count;
    int grants_due;

    // stimulus bookkeeping, fed from accepted requests and grants
    logic              req_kinds  [$];
    logic [SLOT_W-1:0] held_slots [$];
    logic              pool_full_seen = 1'b0;
    logic              send_burst     = 1'b0;
    int                sent           = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fixed_slot_free_list_allocator uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_slot_index (i_slot_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_slot       (o_slot),
        .o_status     (o_status),
        .o_live_count (o_live_count)
    );

    fsfl_pool_checker pool_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_stall    (o_stall),
        .i_req_type     (i_req_type),
        .i_req_slot     (i_slot_index),
        .i_grant_valid  (o_valid),
        .i_grant_stall  (i_stall),
        .i_grant_slot   (o_slot),
        .i_grant_status (o_status),
        .i_grant_live   (o_live_count),
        .o_fault_count  (fault_count),
        .o_grants_due   (grants_due)
    );

    // offer one request after a random gap, return once it is taken
    task automatic send_req(input logic kind, input logic [SLOT_W-1:0] idx);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= kind;
        i_slot_index <= idx;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        req_kinds.push_back(kind);
        sent++;
        if (sent % 50 == 0)
            send_burst = ($urandom_range(0, 3) == 0);
    endtask

    // mostly free a slot known to be held, sometimes any index
    task automatic send_free();
        logic [SLOT_W-1:0] idx;
        int                j;
        if (held_slots.size() > 0 && $urandom_range(0, 99) < 85) begin
            j   = $urandom_range(0, held_slots.size() - 1);
            idx = held_slots[j];
            held_slots.delete(j);
        end else begin
            idx = SLOT_W'($urandom_range(0, SLOTS - 1));
        end
        send_req(REQ_FREE, idx);
    endtask

    // stop offering until every grant has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (grants_due != 0) @(posedge i_clk);
    endtask

    // request side
    initial begin
        int alloc_pct;
        alloc_pct = 50;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: pops, pushes, double frees, ignored index on allocate
        send_req(REQ_ALLOC, '0);
        send_req(REQ_ALLOC, '1);
        send_req(REQ_ALLOC, 10'h155);
        send_req(REQ_FREE, 10'd1);
        send_req(REQ_FREE, 10'd1);    // same slot again
        send_req(REQ_FREE, '1);       // never handed out
        send_req(REQ_FREE, 10'd0);
        send_req(REQ_ALLOC, 10'h2AA);
        send_req(REQ_ALLOC, '0);
        send_req(REQ_ALLOC, '0);
        send_req(REQ_FREE, 10'h2AA);
        send_req(REQ_FREE, 10'd2);
        send_req(REQ_FREE, 10'd3);
        send_req(REQ_FREE, 10'd0);
        send_req(REQ_ALLOC, '1);
        send_req(REQ_ALLOC, '0);
        wait_drained();

        // fill the pool until it runs dry, then a few more allocates
        while (!pool_full_seen)
            send_req(REQ_ALLOC, SLOT_W'($urandom));
        repeat (3) send_req(REQ_ALLOC, SLOT_W'($urandom));

        // random mix: allocate bias 25 percent for the first 200 requests, then redrawn every 50
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 50 == 0)
                alloc_pct = (n < 200) ? 25 : 20 + 30 * $urandom_range(0, 2);
            if ($urandom_range(0, 99) < alloc_pct)
                send_req(REQ_ALLOC, SLOT_W'($urandom));
            else
                send_free();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fault_count == 0 && grants_due == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // grant side: random stalls, two long hold-offs
    initial begin
        int   hold;
        int   taken;
        logic kind;
        logic recv_burst;
        taken      = 0;
        recv_burst = 1'b0;
        wait (i_rst_n);
        forever begin
            hold = recv_burst ? 0 : $urandom_range(0, 5);
            if (taken == 30 || taken == 1400)
                hold = HOLD_OFF_CYCLES;
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            taken++;
            if (taken % 50 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            if (o_status == ST_EXHAUSTED)
                pool_full_seen = 1'b1;
            if (req_kinds.size() > 0) begin
                kind = req_kinds.pop_front();
                if (kind == REQ_ALLOC && o_status == ST_OK)
                    held_slots.push_back(o_slot);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    initial begin
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/fsfl_pkg.sv
rtl/fsfl_ctrl.sv
rtl/fsfl_dp.sv
rtl/fixed_slot_free_list_allocator.sv
dv/fsfl_pool_checker.sv
dv/tb_fixed_slot_free_list_allocator.sv
